FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/umj_pkg.sv
`timescale 1ns / 1ps

package umj_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Position counter inside one job: up to two six-character escapes.
    localparam int          ESC_LEN       = 6;
    localparam logic [3:0]  LAST_IDX_HEX1 = 4'd5;
    localparam logic [3:0]  LAST_IDX_HEX2 = 4'd11;
    localparam logic [3:0]  LAST_IDX_PAIR = 4'd1;
    localparam logic [3:0]  LAST_IDX_ONE  = 4'd0;

    localparam logic [6:0] CH_UNDER  = 7'h5F;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_ONE    = 7'h31;
    localparam logic [6:0] CH_TWO    = 7'h32;
    localparam logic [6:0] CH_THREE  = 7'h33;
    localparam logic [6:0] CH_NONE   = 7'h00;

    localparam logic [15:0] U_LPAREN = 16'h0028;
    localparam logic [15:0] U_RPAREN = 16'h0029;
    localparam logic [15:0] U_DOT    = 16'h002E;
    localparam logic [15:0] U_SLASH  = 16'h002F;
    localparam logic [15:0] U_UNDER  = 16'h005F;
    localparam logic [15:0] U_SEMI   = 16'h003B;
    localparam logic [15:0] U_LBRACK = 16'h005B;

    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef enum logic [2:0] {
        JOB_PASS,
        JOB_UNDER,
        JOB_PAIR,
        JOB_HEX1,
        JOB_HEX2,
        JOB_MARK
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] unit0;     // character, pair second char, or first escaped unit
        logic [15:0] unit1;     // second escaped unit of a surrogate pair
        logic        name_end;
        logic        trunc;
    } job_t;

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        logic [6:0] wide;
        wide = {3'b000, nib};
        if (nib < 4'd10)
            hex_ascii = 7'h30 + wide;
        else
            hex_ascii = 7'h57 + wide;
    endfunction

endpackage

FILE: hw/rtl/umj_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module umj_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          dex_mode,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          end_of_name,
    input  logic          queue_full,
    output logic          push_valid,
    output umj_pkg::job_t push_job
);
    import umj_pkg::*;

    logic [20:0] code_accum_reg, code_accum_next;
    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic [1:0]  seq_len_reg, seq_len_next;
    logic        stopped_reg, stopped_next;

    logic        accept;
    logic        has_unit;
    logic        has_out;
    logic [15:0] unit;
    logic [20:0] acc_shift;
    logic [20:0] supp;
    logic        is_alnum;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign acc_shift = {code_accum_reg[14:0], in_byte[5:0]};
    assign supp      = acc_shift - SUPP_BASE;

    assign is_alnum = (unit >= 16'h0061 && unit <= 16'h007A) ||
                      (unit >= 16'h0041 && unit <= 16'h005A) ||
                      (unit >= 16'h0030 && unit <= 16'h0039);

    always_comb
    begin
        code_accum_next    = code_accum_reg;
        bytes_pending_next = bytes_pending_reg;
        seq_len_next       = seq_len_reg;
        stopped_next       = stopped_reg;
        has_unit           = 1'b0;
        has_out            = 1'b0;
        unit               = 16'h0000;
        push_job.kind      = JOB_MARK;
        push_job.unit0     = 16'h0000;
        push_job.unit1     = 16'h0000;

        // Decode the byte unless a closing paren already muted the name.
        if (!stopped_reg)
        begin
            if (bytes_pending_reg == 2'd0)
            begin
                if (in_byte < 8'h80)
                begin
                    has_unit = 1'b1;
                    unit     = {8'h00, in_byte};
                end
                else if (in_byte < 8'hE0)
                begin
                    code_accum_next    = {16'h0000, in_byte[4:0]};
                    bytes_pending_next = 2'd1;
                    seq_len_next       = 2'd1;
                end
                else if (in_byte < 8'hF0)
                begin
                    code_accum_next    = {17'h00000, in_byte[3:0]};
                    bytes_pending_next = 2'd2;
                    seq_len_next       = 2'd2;
                end
                else
                begin
                    code_accum_next    = {18'h00000, in_byte[2:0]};
                    bytes_pending_next = 2'd3;
                    seq_len_next       = 2'd3;
                end
            end
            else
            begin
                code_accum_next    = acc_shift;
                bytes_pending_next = bytes_pending_reg - 2'd1;
                if (bytes_pending_reg == 2'd1)
                begin
                    if (seq_len_reg == 2'd3)
                    begin
                        has_out        = 1'b1;
                        push_job.kind  = JOB_HEX2;
                        push_job.unit0 = {5'b11011, supp[20:10]};
                        push_job.unit1 = {6'b110111, supp[9:0]};
                    end
                    else
                    begin
                        has_unit = 1'b1;
                        unit     = acc_shift[15:0];
                    end
                    code_accum_next = 21'h000000;
                    seq_len_next    = 2'd0;
                end
            end
        end

        // Classify a finished unit.
        if (has_unit)
        begin
            has_out = 1'b1;
            if (dex_mode && unit == U_LPAREN)
            begin
                push_job.kind  = JOB_PAIR;
                push_job.unit0 = {9'h000, CH_UNDER};
            end
            else if (dex_mode && unit == U_RPAREN)
            begin
                has_out      = 1'b0;
                stopped_next = 1'b1;
            end
            else if (is_alnum)
            begin
                push_job.kind  = JOB_PASS;
                push_job.unit0 = unit;
            end
            else if (unit == U_DOT || unit == U_SLASH)
            begin
                push_job.kind = JOB_UNDER;
            end
            else if (unit == U_UNDER)
            begin
                push_job.kind  = JOB_PAIR;
                push_job.unit0 = {9'h000, CH_ONE};
            end
            else if (unit == U_SEMI)
            begin
                push_job.kind  = JOB_PAIR;
                push_job.unit0 = {9'h000, CH_TWO};
            end
            else if (unit == U_LBRACK)
            begin
                push_job.kind  = JOB_PAIR;
                push_job.unit0 = {9'h000, CH_THREE};
            end
            else
            begin
                push_job.kind  = JOB_HEX1;
                push_job.unit0 = unit;
            end
        end

        // A partial sequence left at the name end is dropped and flagged.
        push_job.name_end = end_of_name;
        push_job.trunc    = end_of_name && (bytes_pending_next != 2'd0);

        if (end_of_name)
        begin
            code_accum_next    = 21'h000000;
            bytes_pending_next = 2'd0;
            seq_len_next       = 2'd0;
            stopped_next       = 1'b0;
        end

        push_valid = accept && (has_out || end_of_name);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_accum_reg    <= '0;
            bytes_pending_reg <= '0;
            seq_len_reg       <= '0;
            stopped_reg       <= 1'b0;
        end
        else if (accept)
        begin
            code_accum_reg    <= code_accum_next;
            bytes_pending_reg <= bytes_pending_next;
            seq_len_reg       <= seq_len_next;
            stopped_reg       <= stopped_next;
        end
    end

    `ASSERT_IMPLY(a_mute_no_pending, clk, rst_n, stopped_reg, bytes_pending_reg == 2'd0, "muted name holds a partial sequence")
    `ASSERT_NEXT(a_end_clears, clk, rst_n, accept && end_of_name, bytes_pending_reg == 2'd0 && !stopped_reg, "name end did not clear decoder")

endmodule

FILE: hw/rtl/umj_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module umj_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  umj_pkg::job_t push_job,
    output logic          full,
    output logic          head_valid,
    output umj_pkg::job_t head_job,
    input  logic          pop
);
    import umj_pkg::*;

    job_t                   slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push_valid, !full, "push into full queue")
    `ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

FILE: hw/rtl/umj_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module umj_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  umj_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [6:0]    out_char,
    output logic          char_valid,
    output logic          last_of_run,
    output logic          name_done,
    output logic          truncated
);
    import umj_pkg::*;

    logic [3:0]  idx_reg;
    logic        out_valid_reg;
    logic [6:0]  out_char_reg;
    logic        char_valid_reg;
    logic        last_reg;
    logic        done_reg;
    logic        trunc_reg;

    logic        load;
    logic        at_last;
    logic [3:0]  last_idx;
    logic        second_unit;
    logic [2:0]  esc_pos;
    logic [15:0] esc_unit;
    logic [3:0]  nib;
    logic [6:0]  ch;
    logic        ch_valid;

    always_comb
    begin
        case (head_job.kind)
            JOB_HEX1: last_idx = LAST_IDX_HEX1;
            JOB_HEX2: last_idx = LAST_IDX_HEX2;
            JOB_PAIR: last_idx = LAST_IDX_PAIR;
            default:  last_idx = LAST_IDX_ONE;
        endcase
    end

    assign second_unit = (idx_reg >= 4'(ESC_LEN));
    assign esc_pos     = second_unit ? 3'(idx_reg - 4'(ESC_LEN)) : idx_reg[2:0];
    assign esc_unit    = second_unit ? head_job.unit1 : head_job.unit0;

    always_comb
    begin
        case (esc_pos)
            3'd2:    nib = esc_unit[15:12];
            3'd3:    nib = esc_unit[11:8];
            3'd4:    nib = esc_unit[7:4];
            default: nib = esc_unit[3:0];
        endcase
    end

    always_comb
    begin
        ch_valid = 1'b1;
        case (head_job.kind)
            JOB_PASS:  ch = head_job.unit0[6:0];
            JOB_UNDER: ch = CH_UNDER;
            JOB_PAIR:  ch = (idx_reg == 4'd0) ? CH_UNDER : head_job.unit0[6:0];
            JOB_HEX1,
            JOB_HEX2:
            begin
                if (esc_pos == 3'd0)
                    ch = CH_UNDER;
                else if (esc_pos == 3'd1)
                    ch = CH_ZERO;
                else
                    ch = hex_ascii(nib);
            end
            default:
            begin
                ch       = CH_NONE;
                ch_valid = 1'b0;
            end
        endcase
    end

    assign at_last = (idx_reg == last_idx);
    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign pop     = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= at_last ? 4'd0 : idx_reg + 4'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg   <= ch;
            char_valid_reg <= ch_valid;
            last_reg       <= at_last;
            done_reg       <= at_last && head_job.name_end;
            trunc_reg      <= at_last && head_job.trunc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign char_valid  = char_valid_reg;
    assign last_of_run = last_reg;
    assign name_done   = done_reg;
    assign truncated   = trunc_reg;

    `ASSERT_IMPLY(a_done_is_last, clk, rst_n, out_valid_reg && done_reg, last_reg, "name end not on final char of its byte")
    `ASSERT_IMPLY(a_bare_marker, clk, rst_n, out_valid_reg && !char_valid_reg, done_reg, "bare marker without name end")

endmodule

FILE: hw/rtl/utf8_jni_name_mangler_core.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------------
// in        | request   | in_valid / in_ready  | in_byte, end_of_name
// out       | result    | out_valid/ out_ready | out_char, char_valid, last_of_run,
//           |           |                      | name_done, truncated
// cfg       | write     | cfg_valid/ cfg_ready | cfg_data (dex_mode)
//
// Rates: one request per cycle enters while the job queue has room; each
//   request yields 0 to 12 characters, shown one per cycle from the output
//   register while out_ready is high; an escape gives 6 characters, a surrogate pair 12.
// The front end decodes UTF-8 and classifies each unit into a job; a
//   four-entry queue separates it from the back end, which expands jobs.
// Reset clears decoder state, queue pointers, output valid and dex_mode.
// Stalls: out_ready low holds the output register; a full queue drops in_ready.
module utf8_jni_name_mangler_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_name,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       char_valid,
    output logic       last_of_run,
    output logic       name_done,
    output logic       truncated,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import umj_pkg::*;

    logic dex_mode_reg;

    logic queue_full;
    logic push_valid;
    job_t push_job;
    logic head_valid;
    job_t head_job;
    logic pop;

    // Writes must land only while idle, a duty of the user that the block leaves unchecked; take them at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dex_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            dex_mode_reg <= cfg_data;
    end

    // Decode bytes and classify finished units.
    umj_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .dex_mode    (dex_mode_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_name (end_of_name),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    // Hold jobs between decode and expansion.
    umj_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    // Expand each job into characters, one per cycle while out_ready is high.
    umj_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .last_of_run (last_of_run),
        .name_done   (name_done),
        .truncated   (truncated)
    );

endmodule

FILE: test/tb_utf8_jni_name_mangler_core.sv
`timescale 1ns / 1ps

module tb_utf8_jni_name_mangler_core;
    import umj_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    // Requests that start a multibyte sequence leave no result behind, so
    // let the decoder and job queue settle before touching dex_mode.
    localparam int SETTLE_CYCLES = 16;
    localparam logic [6:0] CH_LOWER_A = 7'h61;

    // One character (or bare end marker) as it leaves the block.
    typedef struct packed {
        logic [6:0] ch;
        logic       has_char;
        logic       run_end;
        logic       name_end;
        logic       cut;
    } mangled_char_t;

    // Tracks decoder state and holds the characters still owed by the block.
    class mangle_scoreboard;
        logic          dex;
        logic [20:0]   accum;
        logic [1:0]    cont_left;
        logic [1:0]    seq_len;
        logic          halted;
        int            errors;
        mangled_char_t expected_q[$];
        mangled_char_t run_q[$];

        function new();
            dex       = 1'b0;
            accum     = '0;
            cont_left = '0;
            seq_len   = '0;
            halted    = 1'b0;
            errors    = 0;
        endfunction

        function void set_mode(logic m);
            dex = m;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function logic [6:0] hex_char(logic [3:0] v);
            if (v < 4'd10)
                return CH_ZERO + {3'b000, v};
            return CH_LOWER_A + {3'b000, v} - 7'd10;
        endfunction

        function void put_char(logic [6:0] c);
            mangled_char_t r;
            r = '{ch: c, has_char: 1'b1, default: 1'b0};
            run_q.push_back(r);
        endfunction

        function void put_escape(logic [15:0] u);
            put_char(CH_UNDER);
            put_char(CH_ZERO);
            for (int s = 12; s >= 0; s -= 4)
                put_char(hex_char(u[s +: 4]));
        endfunction

        function void put_unit(logic [15:0] u);
            if (dex && u == U_LPAREN)
            begin
                put_char(CH_UNDER);
                put_char(CH_UNDER);
            end
            else if (dex && u == U_RPAREN)
                halted = 1'b1;
            else if ((u >= "a" && u <= "z") || (u >= "A" && u <= "Z") ||
                     (u >= "0" && u <= "9"))
                put_char(u[6:0]);
            else if (u == U_DOT || u == U_SLASH)
                put_char(CH_UNDER);
            else if (u == U_UNDER)
            begin
                put_char(CH_UNDER);
                put_char(CH_ONE);
            end
            else if (u == U_SEMI)
            begin
                put_char(CH_UNDER);
                put_char(CH_TWO);
            end
            else if (u == U_LBRACK)
            begin
                put_char(CH_UNDER);
                put_char(CH_THREE);
            end
            else
                put_escape(u);
        endfunction

        // Advance the decoder by one accepted request and queue its characters.
        function void note_request(logic [7:0] b, logic eon);
            logic [20:0]   d;
            logic          cut;
            mangled_char_t r;
            int            k;
            cut = 1'b0;
            run_q.delete();
            if (!halted)
            begin
                if (cont_left == 2'd0)
                begin
                    if (b < 8'h80)
                        put_unit({8'h00, b});
                    else if (b < 8'hE0)
                    begin
                        accum = {16'h0, b[4:0]};
                        cont_left = 2'd1;
                        seq_len = 2'd1;
                    end
                    else if (b < 8'hF0)
                    begin
                        accum = {17'h0, b[3:0]};
                        cont_left = 2'd2;
                        seq_len = 2'd2;
                    end
                    else
                    begin
                        accum = {18'h0, b[2:0]};
                        cont_left = 2'd3;
                        seq_len = 2'd3;
                    end
                end
                else
                begin
                    accum = {accum[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                    begin
                        if (seq_len == 2'd3)
                        begin
                            // Surrogate pair; out-of-range values just wrap.
                            d = accum - SUPP_BASE;
                            put_escape(16'hD800 | {5'b0, d[20:10]});
                            put_escape(16'hDC00 | {6'b0, d[9:0]});
                        end
                        else
                            put_unit(accum[15:0]);
                        accum = '0;
                        seq_len = '0;
                    end
                end
            end
            if (eon)
            begin
                cut = (cont_left != 2'd0) && !halted;
                if (run_q.size() == 0)
                begin
                    r = '0;
                    run_q.push_back(r);
                end
                accum = '0;
                cont_left = '0;
                seq_len = '0;
                halted = 1'b0;
            end
            if (run_q.size() > 0)
            begin
                k = run_q.size() - 1;
                r = run_q[k];
                r.run_end = 1'b1;
                r.name_end = eon;
                r.cut = eon & cut;
                run_q[k] = r;
            end
            foreach (run_q[i])
                expected_q.push_back(run_q[i]);
        endfunction

        function void check_result(mangled_char_t got);
            mangled_char_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display({"unexpected character: ch=%h has_char=%b run_end=%b ",
                              "name_end=%b cut=%b"},
                             got.ch, got.has_char, got.run_end, got.name_end, got.cut);
                return;
            end
            want = expected_q.pop_front();
            if (got.ch !== want.ch || got.has_char !== want.has_char ||
                got.run_end !== want.run_end || got.name_end !== want.name_end ||
                got.cut !== want.cut)
            begin
                errors++;
                if (errors <= 10)
                    $display({"char mismatch: exp ch=%h v=%b l=%b d=%b t=%b, ",
                              "got ch=%h v=%b l=%b d=%b t=%b"},
                             want.ch, want.has_char, want.run_end, want.name_end, want.cut,
                             got.ch, got.has_char, got.run_end, got.name_end, got.cut);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_name = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [6:0] out_char;
    logic       char_valid;
    logic       last_of_run;
    logic       name_done;
    logic       truncated;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    mangle_scoreboard sb = new;
    logic [7:0] name_buf[$];
    int         burst_left = 0;
    int         cycles = 0;
    logic [1:0] stall_style = 2'd0;
    int         style_left = 0;
    int         hold_left = 0;

    utf8_jni_name_mangler_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_name (end_of_name),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .last_of_run (last_of_run),
        .name_done   (name_done),
        .truncated   (truncated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("utf8_jni_name_mangler_core: mismatch");
            $finish;
        end
    end

    // Output side: check each accepted character, then pick the next ready.
    // The stall style is redrawn when its random countdown expires: always ready,
    // coin flip, one-in-three, or long runs of stall and ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{ch: out_char, has_char: char_valid, run_end: last_of_run,
                              name_end: name_done, cut: truncated});
        if (style_left == 0)
        begin
            stall_style <= 2'($urandom_range(0, 3));
            style_left <= $urandom_range(20, 120);
        end
        else
            style_left <= style_left - 1;
        case (stall_style)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (cycles % 3 == 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    out_ready <= ~out_ready;
                    hold_left <= $urandom_range(1, 15);
                end
                else
                    hold_left <= hold_left - 1;
            end
        endcase
    end

    // Present one request and hold it until accepted. Gaps of random length
    // fall between bursts; an occasional long burst runs with no gaps at all.
    task automatic send_byte(input logic [7:0] b, input logic eon);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
        end
        in_byte <= b;
        end_of_name <= eon;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(b, eon);
        burst_left--;
    endtask

    task automatic send_name();
        for (int k = 0; k < name_buf.size(); k++)
            send_byte(name_buf[k], k == name_buf.size() - 1);
    endtask

    // Drop valid and wait until every owed character is out, then settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_data <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_mode(m);
        cfg_valid <= 1'b0;
    endtask

    // Continuation byte, now and then with bad top bits (not checked).
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Append one symbol of a name: plain, special, or multibyte.
    function automatic void add_symbol();
        int k;
        logic [7:0] punct[7];
        punct = '{U_DOT[7:0], U_SLASH[7:0], U_UNDER[7:0], U_SEMI[7:0],
                  U_LBRACK[7:0], U_LPAREN[7:0], U_RPAREN[7:0]};
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                k = $urandom_range(0, 61);
                if (k < 10)
                    name_buf.push_back(8'("0" + k));
                else if (k < 36)
                    name_buf.push_back(8'("A" + k - 10));
                else
                    name_buf.push_back(8'("a" + k - 36));
            end
            3: name_buf.push_back(punct[$urandom_range(0, 6)]);
            4: name_buf.push_back(8'($urandom_range(0, 127)));
            5:
            begin
                name_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                name_buf.push_back(cont_byte());
            end
            6:
            begin
                name_buf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) name_buf.push_back(cont_byte());
            end
            7:
            begin
                // Mostly legal four-byte leads, some above the Unicode range.
                if ($urandom_range(0, 3) == 0)
                    name_buf.push_back(8'($urandom_range(8'hF5, 8'hFF)));
                else
                    name_buf.push_back(8'($urandom_range(8'hF0, 8'hF4)));
                repeat (3) name_buf.push_back(cont_byte());
            end
            8:
            begin
                // Stray continuation byte read as a two-byte lead.
                name_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
                name_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: name_buf.push_back(($urandom_range(0, 1) == 0) ? U_LPAREN[7:0]
                                                                    : U_RPAREN[7:0]);
        endcase
    endfunction

    // Mostly well-formed names with random content; some end inside a
    // sequence, and some stretches are raw noise with random end marks.
    task automatic random_phase(input int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                sent += n;
            end
            else
            begin
                name_buf.delete();
                repeat ($urandom_range(1, 6)) add_symbol();
                if ($urandom_range(0, 5) == 0)
                begin
                    n = $urandom_range(1, 3);
                    name_buf.push_back((n == 1) ? 8'($urandom_range(8'hC0, 8'hDF)) :
                                       (n == 2) ? 8'($urandom_range(8'hE0, 8'hEF)) :
                                                  8'($urandom_range(8'hF0, 8'hFF)));
                    repeat ($urandom_range(0, n - 1)) name_buf.push_back(cont_byte());
                end
                send_name();
                sent += name_buf.size();
            end
        end
    endtask

    initial
    begin
        logic mode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        // Letters, digits, every plain special, and a one-byte escape.
        name_buf = '{"a", ".", "Z", "_", "9", ";", "[", "/", 8'h7F};
        send_name();
        // Two-, three- and four-byte sequences.
        name_buf = '{8'hC3, 8'hA9};
        send_name();
        name_buf = '{8'hE2, 8'h82, 8'hAC};
        send_name();
        name_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_name();
        // Lead above 0xF7 giving a value below the supplementary base.
        name_buf = '{8'hF8, 8'h80, 8'h80, 8'h80};
        send_name();
        // Stray continuation as lead, then a name cut inside a sequence.
        name_buf = '{8'h80, "A", 8'hE2};
        send_name();
        drain();

        write_mode(1'b1);
        // Paren handling; the open lead after ')' must not flag truncation.
        name_buf = '{"(", ")", 8'hE2};
        send_name();
        // Mode change within a name.
        send_byte("(", 1'b0);
        drain();
        write_mode(1'b0);
        send_byte("(", 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            mode = (p < 4) ? ~p[0] : 1'($urandom_range(0, 1));
            write_mode(mode);
            if (p == 2)
            begin
                // Hold off mid-phase until the block has emptied.
                random_phase(14);
                drain();
                random_phase(14);
            end
            else
                random_phase(28);
        end
        drain();

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("utf8_jni_name_mangler_core: match");
        else
            $display("utf8_jni_name_mangler_core: mismatch");
        $finish;
    end

endmodule

FILE: utf8_jni_name_mangler_core.f
+incdir+hw/rtl
hw/rtl/umj_pkg.sv
hw/rtl/umj_front.sv
hw/rtl/umj_queue.sv
hw/rtl/umj_back.sv
hw/rtl/utf8_jni_name_mangler_core.sv
test/tb_utf8_jni_name_mangler_core.sv
